>>> src/ppu_pkg.sv
// Shared types and constants for the packed pixel unpacker.
// No dependencies; used by ppu_front, ppu_back and the top level.
`default_nettype none

package ppu_pkg;

  // Configuration register layout
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DEPTH_W    = 3;
  localparam int unsigned LINE_W_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  localparam logic [DEPTH_W-1:0]  DEPTH_RESET      = 3'd3;
  localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET = 13'd640;

  // Input word kind (tuser)
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_PAL  = 1'b1;

  // Depth modes; code 7 is unused and decodes as 8 bpp palette
  typedef enum logic [DEPTH_W-1:0] {
    DM_1BPP   = 3'd0,
    DM_2BPP   = 3'd1,
    DM_4BPP   = 3'd2,
    DM_8BPP   = 3'd3,
    DM_WORD16 = 3'd4,
    DM_RGB24  = 3'd5,
    DM_ARGB32 = 3'd6
  } depth_mode_e;

  // How a pixel request is turned into output fields
  typedef enum logic [1:0] {
    PK_PAL,
    PK_WORD,
    PK_RGB,
    PK_ARGB
  } pix_kind_e;

  // One pixel on its way from the expander to the output stage
  typedef struct packed {
    pix_kind_e   kind;
    logic        idx_ok;  // palette index is inside the palette
    logic [31:0] value;   // gathered bytes for the direct modes
    logic        eol;
    logic        last;
  } pix_req_t;

endpackage

`default_nettype wire

>>> src/ppu_palette_ram.sv
// Palette memory: 24-bit RGB entries, one write and one read port.
// Synchronous (registered) read; uses no package items.
`default_nettype none

module ppu_palette_ram #(
  parameter int unsigned ENTRIES = 256
) (
  input  wire                        clk_i,
  input  wire                        wr_en_i,
  input  wire [$clog2(ENTRIES)-1:0]  wr_addr_i,
  input  wire [23:0]                 wr_data_i,
  input  wire                        rd_en_i,
  input  wire [$clog2(ENTRIES)-1:0]  rd_addr_i,
  output logic [23:0]                rd_data_o
);

  logic [23:0] mem_q [ENTRIES];
  logic [23:0] rd_data_q;

  // read returns the old entry on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/ppu_front.sv
// Front end: line/byte counters, byte gathering and the pixel expander
// that issues one palette read per palette-mode pixel. Depends on ppu_pkg.
`default_nettype none

module ppu_front #(
  parameter int unsigned MAX_LINE_WIDTH  = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input word
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                cmd_i,
  input  wire [7:0]                          data_byte_i,
  input  wire [7:0]                          pal_index_i,
  input  wire [23:0]                         pal_rgb_i,
  // configuration
  input  wire [ppu_pkg::DEPTH_W-1:0]         depth_mode_i,
  input  wire [ppu_pkg::LINE_W_W-1:0]        line_width_i,
  // palette memory
  output logic                               pal_we_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_waddr_o,
  output logic [23:0]                        pal_wdata_o,
  output logic                               rd_en_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr_o,
  // pixel requests
  output logic                               req_valid_o,
  input  wire                                req_ready_i,
  output ppu_pkg::pix_req_t                  req_o
);

  localparam int unsigned PIX_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned BYTE_W = PIX_W + 2;
  localparam int unsigned WB_W   = PIX_W + 5;
  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    ST_1,
    ST_2,
    ST_4,
    ST_8
  } pix_step_e;

  // line state
  logic [PIX_W-1:0]  pix_q, pix_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [23:0]       gather_q, gather_d;
  logic [1:0]        phase_q, phase_d;

  // expander state
  logic                e_valid_q;
  logic [3:0]          e_cnt_q;
  logic [7:0]          e_sh_q;
  pix_step_e           e_step_q;
  ppu_pkg::pix_kind_e  e_kind_q;
  logic [31:0]         e_val_q;
  logic                e_eol_q;

  logic               accept, fire, e_last;
  logic [31:0]        lw32;
  logic [PIX_W-1:0]   width_eff, rem, pix_inc;
  logic [WB_W-1:0]    wx, wb, wb_round;
  logic [BYTE_W-2:0]  half_bytes;
  logic [BYTE_W-1:0]  line_bytes;
  logic [BYTE_W:0]    byte_sum;
  logic               is_pal, active;
  pix_step_e          step;
  logic [3:0]         per, n_pix;
  logic [2:0]         nb, ph1;
  ppu_pkg::pix_kind_e kind;
  logic               load_e, load_eol;
  logic [3:0]         load_cnt;
  logic [7:0]         idx;
  logic [7:0]         sh_next;

  // effective line width: zero reads as one, saturate at the maximum
  always_comb begin
    lw32 = 32'(line_width_i);
    if (lw32 == 32'd0) begin
      width_eff = PIX_W'(1);
    end else if (lw32 > 32'(MAX_LINE_WIDTH)) begin
      width_eff = PIX_W'(MAX_LINE_WIDTH);
    end else begin
      width_eff = PIX_W'(lw32);
    end
  end

  // mode decode and line bits
  assign wx = WB_W'(width_eff);
  always_comb begin
    is_pal = 1'b1;
    step   = ST_8;
    per    = 4'd1;
    nb     = 3'd1;
    kind   = ppu_pkg::PK_PAL;
    wb     = wx << 3;
    unique case (ppu_pkg::depth_mode_e'(depth_mode_i))
      ppu_pkg::DM_1BPP: begin
        step = ST_1;
        per  = 4'd8;
        wb   = wx;
      end
      ppu_pkg::DM_2BPP: begin
        step = ST_2;
        per  = 4'd4;
        wb   = wx << 1;
      end
      ppu_pkg::DM_4BPP: begin
        step = ST_4;
        per  = 4'd2;
        wb   = wx << 2;
      end
      ppu_pkg::DM_WORD16: begin
        is_pal = 1'b0;
        nb     = 3'd2;
        kind   = ppu_pkg::PK_WORD;
        wb     = wx << 4;
      end
      ppu_pkg::DM_RGB24: begin
        is_pal = 1'b0;
        nb     = 3'd3;
        kind   = ppu_pkg::PK_RGB;
        wb     = (wx << 4) + (wx << 3);
      end
      ppu_pkg::DM_ARGB32: begin
        is_pal = 1'b0;
        nb     = 3'd4;
        kind   = ppu_pkg::PK_ARGB;
        wb     = wx << 5;
      end
      default: begin
        // 8 bpp palette and the unused code
        step = ST_8;
      end
    endcase
  end

  // bytes per line: ceil(bits / 8) rounded up to even == 2 * ceil(bits / 16)
  assign wb_round   = wb + WB_W'(15);
  assign half_bytes = (BYTE_W-1)'(wb_round >> 4);
  assign line_bytes = {half_bytes, 1'b0};

  // handshake
  assign e_last     = (e_cnt_q == 4'd1);
  assign fire       = e_valid_q & req_ready_i;
  assign in_ready_o = ~e_valid_q | (req_ready_i & e_last);
  assign accept     = in_valid_i & in_ready_o;

  assign active = (pix_q < width_eff);
  assign rem    = width_eff - pix_q;
  assign n_pix  = (rem < PIX_W'(per)) ? 4'(rem) : per;
  assign ph1    = {1'b0, phase_q} + 3'd1;

  // per-byte line bookkeeping
  always_comb begin
    pix_d    = pix_q;
    byte_d   = byte_q;
    gather_d = gather_q;
    phase_d  = phase_q;
    load_e   = 1'b0;
    load_cnt = 4'd1;
    pix_inc  = pix_q;
    load_eol = 1'b0;
    byte_sum = {1'b0, byte_q} + (BYTE_W+1)'(1);
    if (accept && (cmd_i == ppu_pkg::CMD_DATA)) begin
      if (active) begin
        if (is_pal) begin
          pix_inc  = pix_q + PIX_W'(n_pix);
          pix_d    = pix_inc;
          load_e   = 1'b1;
          load_cnt = n_pix;
          load_eol = (pix_inc == width_eff);
        end else if (ph1 >= nb) begin
          pix_inc  = pix_q + PIX_W'(1);
          pix_d    = pix_inc;
          load_e   = 1'b1;
          load_eol = (pix_inc == width_eff);
          gather_d = '0;
          phase_d  = '0;
        end else begin
          gather_d = {gather_q[15:0], data_byte_i};
          phase_d  = phase_q + 2'd1;
        end
      end
      // end of line, padding included
      if (byte_sum >= {1'b0, line_bytes}) begin
        byte_d   = '0;
        pix_d    = '0;
        gather_d = '0;
        phase_d  = '0;
      end else begin
        byte_d = byte_sum[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q    <= '0;
      byte_q   <= '0;
      gather_q <= '0;
      phase_q  <= '0;
    end else begin
      pix_q    <= pix_d;
      byte_q   <= byte_d;
      gather_q <= gather_d;
      phase_q  <= phase_d;
    end
  end

  // expander: index of the current pixel, most significant bits first
  always_comb begin
    unique case (e_step_q)
      ST_1: begin
        idx     = {7'b0, e_sh_q[7]};
        sh_next = e_sh_q << 1;
      end
      ST_2: begin
        idx     = {6'b0, e_sh_q[7:6]};
        sh_next = e_sh_q << 2;
      end
      ST_4: begin
        idx     = {4'b0, e_sh_q[7:4]};
        sh_next = e_sh_q << 4;
      end
      ST_8: begin
        idx     = e_sh_q;
        sh_next = e_sh_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      e_cnt_q   <= '0;
    end else if (load_e) begin
      e_valid_q <= 1'b1;
      e_cnt_q   <= load_cnt;
    end else if (fire) begin
      e_valid_q <= ~e_last;
      e_cnt_q   <= e_cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_e) begin
      e_sh_q   <= data_byte_i;
      e_step_q <= step;
      e_kind_q <= kind;
      e_val_q  <= {gather_q, data_byte_i};
      e_eol_q  <= load_eol;
    end else if (fire) begin
      e_sh_q <= sh_next;
    end
  end

  assign req_valid_o   = e_valid_q;
  assign req_o.kind    = e_kind_q;
  assign req_o.idx_ok  = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
  assign req_o.value   = e_val_q;
  assign req_o.eol     = e_eol_q & e_last;
  assign req_o.last    = e_last;

  assign rd_en_o   = fire & (e_kind_q == ppu_pkg::PK_PAL);
  assign rd_addr_o = idx[PAL_AW-1:0];

  // palette writes; out-of-range indexes are dropped
  assign pal_we_o    = accept & (cmd_i == ppu_pkg::CMD_PAL) &
                       ({1'b0, pal_index_i} < 9'(PALETTE_ENTRIES));
  assign pal_waddr_o = pal_index_i[PAL_AW-1:0];
  assign pal_wdata_o = pal_rgb_i;

  // a pending byte always has pixels left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> (e_cnt_q != 4'd0))
    else $error("expander valid with zero count");

  // an empty gather holds no bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == 2'd0) |-> (gather_q == 24'd0))
    else $error("gathered bytes without a gather phase");

  // palette write only when no earlier pixel still has to read the palette
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we_o |-> (!e_valid_q || (fire && e_last)))
    else $error("palette write overtakes pending reads");

  // pixel count stays within the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_q <= PIX_W'(MAX_LINE_WIDTH))
    else $error("pixel counter beyond maximum line width");

endmodule

`default_nettype wire

>>> src/ppu_back.sv
// Back end: palette read stage and output register with stream handshake.
// Depends on ppu_pkg.
`default_nettype none

module ppu_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               req_valid_i,
  output logic              req_ready_o,
  input  ppu_pkg::pix_req_t req_i,
  input  wire [23:0]        rd_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [47:0]       out_data_o,   // red, green, blue, alpha, word
  output logic              out_last_o,   // last_of_run
  output logic              out_eol_o     // end_of_line
);

  logic              r_valid_q;
  ppu_pkg::pix_req_t r_req_q;
  logic              out_valid_q;
  logic [47:0]       out_data_q;
  logic              out_last_q, out_eol_q;

  logic        out_ok, r_ready;
  logic [23:0] rgb;
  logic [7:0]  alpha;
  logic [15:0] word;

  assign out_ok      = ~out_valid_q | out_ready_i;
  assign r_ready     = ~r_valid_q | out_ok;
  assign req_ready_o = r_ready;

  // read stage: palette data arrives alongside the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (r_ready) begin
      r_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_ready && req_valid_i) begin
      r_req_q <= req_i;
    end
  end

  // format the pixel
  always_comb begin
    rgb   = '0;
    alpha = '0;
    word  = '0;
    unique case (r_req_q.kind)
      ppu_pkg::PK_PAL: begin
        rgb = r_req_q.idx_ok ? rd_data_i : 24'd0;
      end
      ppu_pkg::PK_WORD: begin
        word = r_req_q.value[15:0];
      end
      ppu_pkg::PK_RGB: begin
        rgb = r_req_q.value[23:0];
      end
      ppu_pkg::PK_ARGB: begin
        rgb   = r_req_q.value[23:0];
        alpha = r_req_q.value[31:24];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ok) begin
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ok && r_valid_q) begin
      out_data_q <= {word, alpha, rgb[7:0], rgb[15:8], rgb[23:16]};
      out_last_q <= r_req_q.last;
      out_eol_q  <= r_req_q.eol;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_eol_o   = out_eol_q;

  // end of line is always the last pixel of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_eol_q) |-> out_last_q)
    else $error("end of line without last of run");

  // a stalled read stage keeps its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && !out_ok) |=> (r_valid_q && $stable(r_req_q)))
    else $error("read stage lost a pixel under stall");

endmodule

`default_nettype wire

>>> src/packed_pixel_unpacker.sv
// Packed pixel unpacker, top level: configuration registers and stage wiring.
// Depends on ppu_pkg, ppu_front, ppu_palette_ram and ppu_back.
//
// Input stream (s_axis): one word per byte of raw video. tuser = 0 carries a
// data byte in tdata[7:0]; tuser = 1 writes palette entry tdata[15:8] with
// red/green/blue from tdata[39:16]. Output stream (m_axis): one word per
// pixel, tlast on the last pixel of an input byte, tuser on the last pixel
// of a line. Padding bytes and partial multi-byte pixels give no word.
// Configuration (cfg_*): index 0 = depth mode, 1 = line width; write only
// while the block is idle.
// A pixel passes the expander, read stage and output register on its way to m_axis.
// Throughput: one pixel per cycle while m_axis does not stall, set by the single
// palette read port; a byte holds the input until its last pixel is sent (up to
// 8 at 1 bpp), and bytes with at most one pixel are taken every cycle unless stalled.
// Reset clears the line counters and pipeline, sets depth mode 8 bpp and
// line width 640; palette contents are undefined until written.
// When m_axis stalls, the output register and read stage hold their pixels
// and s_axis_tready drops once the expander cannot move.
`default_nettype none

module packed_pixel_unpacker #(
  parameter int unsigned MAX_LINE_WIDTH  = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [39:0]                       s_axis_tdata,  // data_byte, pal_index,
                                                          // pal_red, pal_green, pal_blue
  input  wire                              s_axis_tuser,  // command
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // out_red, out_green,
                                                          // out_blue, out_alpha, out_word
  output logic                             m_axis_tlast,  // last_of_run
  output logic                             m_axis_tuser,  // end_of_line
  // configuration
  input  wire                              cfg_we_i,
  input  wire [ppu_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire [ppu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

  logic [ppu_pkg::DEPTH_W-1:0]  depth_mode_q;
  logic [ppu_pkg::LINE_W_W-1:0] line_width_q;

  logic              pal_we, rd_en;
  logic [PAL_AW-1:0] pal_waddr, rd_addr;
  logic [23:0]       pal_wdata, rd_data;
  logic              req_valid, req_ready;
  ppu_pkg::pix_req_t req;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q <= ppu_pkg::DEPTH_RESET;
      line_width_q <= ppu_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ppu_pkg::CFG_DEPTH_MODE: depth_mode_q <= cfg_data_i[ppu_pkg::DEPTH_W-1:0];
        ppu_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data_i[ppu_pkg::LINE_W_W-1:0];
        default: ;
      endcase
    end
  end

  ppu_front #(
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .data_byte_i  (s_axis_tdata[7:0]),
    .pal_index_i  (s_axis_tdata[15:8]),
    .pal_rgb_i    ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .depth_mode_i (depth_mode_q),
    .line_width_i (line_width_q),
    .pal_we_o     (pal_we),
    .pal_waddr_o  (pal_waddr),
    .pal_wdata_o  (pal_wdata),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .req_valid_o  (req_valid),
    .req_ready_i  (req_ready),
    .req_o        (req)
  );

  ppu_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (pal_we),
    .wr_addr_i (pal_waddr),
    .wr_data_i (pal_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ppu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eol_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> tb/packed_pixel_unpacker_tb.sv
// Self-checking testbench for packed_pixel_unpacker: a directed table, then random
// traffic, checked against the table's expected pixels or an in-bench pixel predictor.
// Depends on ppu_pkg and the packed_pixel_unpacker RTL.
`timescale 1ns / 1ps

module packed_pixel_unpacker_tb;

  localparam int unsigned MAX_LINE     = 4096;
  localparam int unsigned SETTLE_CYC   = 12;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned LIMIT_CYC    = 500000;
  localparam int unsigned N_PHASES     = 12;
  localparam int unsigned PHASE_WORDS  = 23;
  localparam int unsigned PAL_FILL     = 64;
  localparam int unsigned MAX_PRINTS   = 40;

  // unused depth code, decodes as 8 bpp palette
  localparam logic [ppu_pkg::DEPTH_W-1:0] DM_UNUSED = 3'd7;

  // expected output pixel, packed in the order red, green, blue, alpha, word, eol, last
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] word;
    logic        eol;
    logic        last;
  } pixel_t;

  typedef enum logic [1:0] {R_DEPTH, R_WIDTH, R_PAL, R_BYTE} row_kind_e;

  // one line of the directed table; want is used only when typed is set
  typedef struct packed {
    row_kind_e   kind;
    logic [12:0] arg;    // register value, palette index or data byte
    logic [23:0] rgb;    // palette color
    logic        typed;
    pixel_t      want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // data_byte, pal_index, pal_red, pal_green, pal_blue
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_red, out_green, out_blue, out_alpha, out_word
  logic        m_axis_tlast;        // last_of_run
  logic        m_axis_tuser;        // end_of_line
  logic                           cfg_we_i = 1'b0;
  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  packed_pixel_unpacker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [23:0]                   pal [256];
  logic [ppu_pkg::DEPTH_W-1:0]   cur_depth = ppu_pkg::DEPTH_RESET;
  logic [ppu_pkg::LINE_W_W-1:0]  cur_width = ppu_pkg::LINE_WIDTH_RESET;
  int unsigned                   pix_cnt = 0;
  int unsigned                   byte_pos = 0;
  logic [23:0]                   gather = '0;
  int unsigned                   phase = 0;
  pixel_t                        pix_scratch [8];

  // pixels still owed by the DUT, oldest first
  pixel_t      pix_due [$];
  pixel_t      head_px;
  dir_row_t    dir_rows [$];

  int unsigned err_cnt = 0;
  int unsigned pix_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned pal_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cyc_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  task automatic report_bad(input string what, input int unsigned got_v,
                            input int unsigned want_v);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("%0t: pixel %0d: %s got %0h want %0h", $time, pix_checked, what, got_v,
               want_v);
  endtask

  // Expected pixels for one data byte; fills pix_scratch and returns the count.
  function automatic int unpack_byte(input logic [7:0] b);
    int unsigned bits, w, line_bytes, per, nb, i, mask;
    int n;
    logic [7:0]  idx;
    logic [31:0] v;
    logic [23:0] c;
    n = 0;
    case (cur_depth)
      ppu_pkg::DM_1BPP:   bits = 1;
      ppu_pkg::DM_2BPP:   bits = 2;
      ppu_pkg::DM_4BPP:   bits = 4;
      ppu_pkg::DM_WORD16: bits = 16;
      ppu_pkg::DM_RGB24:  bits = 24;
      ppu_pkg::DM_ARGB32: bits = 32;
      default:            bits = 8;
    endcase
    w = cur_width;
    if (w == 0) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;
    line_bytes = (w * bits + 7) / 8;
    if (line_bytes % 2 == 1) line_bytes++;

    if (pix_cnt < w) begin
      if (bits <= 8) begin
        // palette modes: split the byte MSB first
        per = 8 / bits;
        mask = (1 << bits) - 1;
        for (i = 0; i < per && pix_cnt < w; i++) begin
          idx = 8'((b >> (8 - bits * (i + 1))) & mask);
          c = pal[idx];
          pix_cnt++;
          pix_scratch[n] = {c, 8'h00, 16'h0000, pix_cnt == w, 1'b0};
          n++;
        end
      end else begin
        // direct modes: gather bytes until the pixel is complete
        nb = bits / 8;
        if (phase + 1 >= nb) begin
          v = {gather, b};
          pix_cnt++;
          case (nb)
            2:       pix_scratch[n] = {24'h0, 8'h00, v[15:0], pix_cnt == w, 1'b0};
            3:       pix_scratch[n] = {v[23:0], 8'h00, 16'h0000, pix_cnt == w, 1'b0};
            default: pix_scratch[n] = {v[23:0], v[31:24], 16'h0000, pix_cnt == w, 1'b0};
          endcase
          n++;
          gather = '0;
          phase = 0;
        end else begin
          gather = {gather[15:0], b};
          phase = (phase + 1) % 4;
        end
      end
    end

    // line padding: counters restart once the line's byte count is reached
    byte_pos++;
    if (byte_pos >= line_bytes) begin
      byte_pos = 0;
      pix_cnt = 0;
      gather = '0;
      phase = 0;
    end
    if (n > 0) pix_scratch[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic pixel_t single_px(input logic [23:0] rgb, input logic [7:0] alpha,
                                       input logic [15:0] wd);
    return {rgb, alpha, wd, 1'b0, 1'b1};
  endfunction

  function automatic void add_row(input row_kind_e kind, input int unsigned arg,
                                  input logic [23:0] rgb);
    dir_rows.push_back({kind, arg[12:0], rgb, 1'b0, pixel_t'('0)});
  endfunction

  function automatic void add_checked(input logic [7:0] b, input pixel_t want);
    dir_rows.push_back({R_BYTE, {5'd0, b}, 24'h0, 1'b1, want});
  endfunction

  // Offer one input word, wait for the handshake, then predict its pixels.
  task automatic send_word(input logic cmd, input logic [39:0] data, input logic typed,
                           input pixel_t want);
    int n;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == ppu_pkg::CMD_PAL) begin
      pal[data[15:8]] = {data[23:16], data[31:24], data[39:32]};
      pal_sent++;
    end else begin
      n = unpack_byte(data[7:0]);
      bytes_sent++;
      if (typed) pix_due.push_back(want);
      else for (int i = 0; i < n; i++) pix_due.push_back(pix_scratch[i]);
    end
  endtask

  // Stop offering, let every owed pixel arrive, then give padding bytes time to retire.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pix_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ppu_pkg::CFG_IDX_W-1:0] sel,
                           input int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= sel;
    cfg_data_i <= val[ppu_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == ppu_pkg::CFG_DEPTH_MODE) cur_depth = val[ppu_pkg::DEPTH_W-1:0];
    else cur_width = val[ppu_pkg::LINE_W_W-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Output side: check each accepted word, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pix_due.size() == 0) begin
        report_bad("unexpected word, data low bits", m_axis_tdata[31:0], 0);
      end else begin
        head_px = pix_due.pop_front();
        if (m_axis_tdata[7:0] != head_px.red)
          report_bad("red", m_axis_tdata[7:0], head_px.red);
        if (m_axis_tdata[15:8] != head_px.green)
          report_bad("green", m_axis_tdata[15:8], head_px.green);
        if (m_axis_tdata[23:16] != head_px.blue)
          report_bad("blue", m_axis_tdata[23:16], head_px.blue);
        if (m_axis_tdata[31:24] != head_px.alpha)
          report_bad("alpha", m_axis_tdata[31:24], head_px.alpha);
        if (m_axis_tdata[47:32] != head_px.word)
          report_bad("word", m_axis_tdata[47:32], head_px.word);
        if (m_axis_tuser != head_px.eol)
          report_bad("end_of_line", m_axis_tuser, head_px.eol);
        if (m_axis_tlast != head_px.last)
          report_bad("last_of_run", m_axis_tlast, head_px.last);
        pix_checked++;
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_tgl != hold_seen) begin
      hold_seen     <= hold_tgl;
      hold_left     <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  initial begin
    wait (cyc_cnt >= LIMIT_CYC);
    $display("timeout after %0d cycles, %0d pixels still owed", cyc_cnt, pix_due.size());
    $display("packed_pixel_unpacker_tb: FAIL");
    $finish;
  end

  initial begin
    logic [39:0] rnd;
    int unsigned wval;
    for (int i = 0; i < 256; i++) pal[i] = '0;

    // palette entries used by the directed part come first
    add_row(R_PAL, 8'h00, 24'h000000);
    add_row(R_PAL, 8'hFF, 24'hFFFFFF);
    add_row(R_PAL, 8'h01, 24'h123456);
    add_row(R_PAL, 8'h03, 24'hA5C3E7);
    add_row(R_PAL, 8'h0F, 24'h0F1E2D);
    // 8 bpp palette straight out of reset
    add_checked(8'h00, single_px(24'h000000, 8'h00, 16'h0000));
    add_checked(8'hFF, single_px(24'hFFFFFF, 8'h00, 16'h0000));
    add_checked(8'h01, single_px(24'h123456, 8'h00, 16'h0000));
    // width zero acts as one, changed mid-line; then padding bytes
    add_row(R_WIDTH, 0, 24'h0);
    add_row(R_BYTE, 8'hFF, 24'h0);
    add_row(R_BYTE, 8'h01, 24'h0);
    add_row(R_BYTE, 8'h00, 24'h0);
    // sub-byte modes, width above the maximum saturates
    add_row(R_DEPTH, ppu_pkg::DM_1BPP, 24'h0);
    add_row(R_WIDTH, 8191, 24'h0);
    add_row(R_BYTE, 8'h80, 24'h0);
    add_row(R_DEPTH, ppu_pkg::DM_2BPP, 24'h0);
    add_row(R_BYTE, 8'hC0, 24'h0);
    add_row(R_DEPTH, ppu_pkg::DM_4BPP, 24'h0);
    add_row(R_BYTE, 8'hF0, 24'h0);
    // direct modes, partial pixels give nothing until complete
    add_row(R_DEPTH, ppu_pkg::DM_WORD16, 24'h0);
    add_row(R_BYTE, 8'hAB, 24'h0);
    add_checked(8'hCD, single_px(24'h000000, 8'h00, 16'hABCD));
    add_row(R_DEPTH, ppu_pkg::DM_RGB24, 24'h0);
    add_row(R_BYTE, 8'h11, 24'h0);
    add_row(R_BYTE, 8'h22, 24'h0);
    add_checked(8'h33, single_px(24'h112233, 8'h00, 16'h0000));
    add_row(R_DEPTH, ppu_pkg::DM_ARGB32, 24'h0);
    add_row(R_BYTE, 8'hFF, 24'h0);
    add_row(R_BYTE, 8'h01, 24'h0);
    add_row(R_BYTE, 8'h02, 24'h0);
    add_checked(8'h03, single_px(24'h010203, 8'hFF, 16'h0000));
    // gather cut short by a smaller pixel size
    add_row(R_BYTE, 8'h12, 24'h0);
    add_row(R_BYTE, 8'h34, 24'h0);
    add_row(R_DEPTH, ppu_pkg::DM_WORD16, 24'h0);
    add_row(R_BYTE, 8'h56, 24'h0);
    // unused depth code, single pixel lines
    add_row(R_DEPTH, DM_UNUSED, 24'h0);
    add_row(R_WIDTH, 1, 24'h0);
    add_row(R_BYTE, 8'hFF, 24'h0);
    add_row(R_BYTE, 8'h01, 24'h0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        R_DEPTH: begin
          drain();
          write_reg(ppu_pkg::CFG_DEPTH_MODE, dir_rows[k].arg);
        end
        R_WIDTH: begin
          drain();
          write_reg(ppu_pkg::CFG_LINE_WIDTH, dir_rows[k].arg);
        end
        R_PAL: send_word(ppu_pkg::CMD_PAL, {dir_rows[k].rgb[7:0], dir_rows[k].rgb[15:8],
                                   dir_rows[k].rgb[23:16], dir_rows[k].arg[7:0], 8'h00},
                         1'b0, '0);
        default: send_word(ppu_pkg::CMD_DATA, {32'h0, dir_rows[k].arg[7:0]},
                           dir_rows[k].typed, dir_rows[k].want);
      endcase
    end

    // fill the low palette entries; random indexes stay inside them
    drain();
    tx_idle_pct = 30;
    for (int i = 0; i < PAL_FILL; i++) begin
      rnd[31:0]  = $urandom();
      rnd[39:32] = $urandom_range(255);
      rnd[15:8]  = i[7:0];
      send_word(ppu_pkg::CMD_PAL, rnd, 1'b0, '0);
    end

    // random phases: every depth code, extreme and small widths, four idle patterns
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0:       wval = 1;
        1:       wval = MAX_LINE;
        2:       wval = 0;
        3:       wval = 8191;
        default: wval = $urandom_range(1, 12);
      endcase
      write_reg(ppu_pkg::CFG_DEPTH_MODE, p % 8);
      write_reg(ppu_pkg::CFG_LINE_WIDTH, wval);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 62; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 62; end
        default: begin tx_idle_pct = 30; rx_stall_pct <= 30; end
      endcase
      // back-pressure: output held off while the input keeps coming
      if (p == 4) hold_tgl <= ~hold_tgl;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        rnd[31:0]  = $urandom();
        rnd[39:32] = $urandom_range(255);
        // 8 bpp bytes index only the filled entries
        if (cur_depth == ppu_pkg::DM_8BPP || cur_depth == DM_UNUSED)
          rnd[7:0] = 8'(rnd[7:0] % PAL_FILL);
        if ($urandom_range(99) < 8) send_word(ppu_pkg::CMD_PAL, rnd, 1'b0, '0);
        else send_word(ppu_pkg::CMD_DATA, rnd, 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d data bytes and %0d palette writes over %0d register writes",
             bytes_sent, pal_sent, cfg_writes);
    $display("%0d pixels compared, %0d mismatches", pix_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("packed_pixel_unpacker_tb: PASS");
    end else begin
      $display("packed_pixel_unpacker_tb: FAIL");
    end
    $finish;
  end

endmodule
